### sv/checksummed_frame_receiver_assert.svh
// Assertion macros for the checksummed frame receiver, used by cfr_outq.
`ifndef CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`define CHECKSUMMED_FRAME_RECEIVER_ASSERT_SVH
`ifndef SYNTHESIS
// Clocked check on clk, held off while arst_n is low.
`define CFR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Clocked check on clk that also holds during reset.
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CFR_ASSERT(lbl, prop, msg)
`define CFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### sv/cfr_pkg.sv
// Types and constants of the checksummed frame receiver.
package cfr_pkg;

	localparam logic [7:0] START_RESET = 8'h99;
	localparam logic [7:0] HEADER_END  = 8'd6;
	localparam logic [7:0] MIN_LENGTH  = 8'd8;

	// Config port: 3-bit byte address, one 32-bit register
	localparam int PADDR_W = 3;
	localparam logic [PADDR_W-3:0] REG_START_BYTE = '0;

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN,
		PH_HEADER,
		PH_PAYLOAD,
		PH_CKA,
		PH_CKB
	} phase_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD,
		KIND_GOOD,
		KIND_BAD,
		KIND_SHORT
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data_byte;
		logic [7:0] payload_index;
		logic [7:0] source_id;
		logic [7:0] dest_id;
		logic [3:0] cls_code;
		logic [3:0] comp_code;
		logic [7:0] msg_code;
		logic [7:0] frame_length;
	} result_t;

endpackage

### sv/cfr_regs.sv
// Configuration register block (start byte) behind the APB-style port.
module cfr_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output logic [7:0]                  start_byte
);

	logic [7:0]                  start_q;
	logic [cfr_pkg::PADDR_W-3:0] reg_idx;
	logic                        wr_en;

	assign reg_idx = paddr[cfr_pkg::PADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;

	// Register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= cfr_pkg::START_RESET;
		end else if (wr_en && reg_idx == cfr_pkg::REG_START_BYTE) begin
			start_q <= pwdata[7:0];
		end
	end

	// Read mux
	always_comb begin
		prdata = '0;
		if (reg_idx == cfr_pkg::REG_START_BYTE) begin
			prdata = {24'd0, start_q};
		end
	end

	assign start_byte = start_q;

endmodule

### sv/cfr_parse.sv
// Frame parser: phase tracking, header capture and running checksums.
module cfr_parse (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic [7:0]       rx_byte,
	input  logic [7:0]       start_byte,
	output logic             res_valid,
	output cfr_pkg::result_t res
);

	cfr_pkg::phase_t phase_q, phase_d;
	logic [7:0] byte_count_q, byte_count_d;
	logic [7:0] exp_len_q, exp_len_d;
	logic [7:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic [7:0] src_q, src_d, dst_q, dst_d, cc_q, cc_d, msg_q, msg_d;
	logic [7:0] ck_a_q, ck_a_d;
	logic [7:0] sum_a_add, sum_b_add, count_inc;
	logic [8:0] payload_end;
	logic       with_header;

	// Fletcher sums with the current byte folded in
	assign sum_a_add   = sum_a_q + rx_byte;
	assign sum_b_add   = sum_b_q + sum_a_add;
	assign count_inc   = byte_count_q + 8'd1;
	assign payload_end = {1'b0, byte_count_q} + 9'd3;

	// Next phase
	always_comb begin
		phase_d = cfr_pkg::PH_HUNT;
		unique case (phase_q)
			cfr_pkg::PH_LEN: begin
				phase_d = (rx_byte < cfr_pkg::MIN_LENGTH) ? cfr_pkg::PH_HUNT
				                                         : cfr_pkg::PH_HEADER;
			end
			cfr_pkg::PH_HEADER: begin
				if (count_inc >= cfr_pkg::HEADER_END) begin
					phase_d = (exp_len_q == cfr_pkg::MIN_LENGTH) ? cfr_pkg::PH_CKA
					                                            : cfr_pkg::PH_PAYLOAD;
				end else begin
					phase_d = cfr_pkg::PH_HEADER;
				end
			end
			cfr_pkg::PH_PAYLOAD: begin
				phase_d = (payload_end >= {1'b0, exp_len_q}) ? cfr_pkg::PH_CKA
				                                            : cfr_pkg::PH_PAYLOAD;
			end
			cfr_pkg::PH_CKA: phase_d = cfr_pkg::PH_CKB;
			cfr_pkg::PH_CKB: phase_d = cfr_pkg::PH_HUNT;
			default: begin
				phase_d = (rx_byte == start_byte) ? cfr_pkg::PH_LEN : cfr_pkg::PH_HUNT;
			end
		endcase
	end

	// Datapath updates and result
	always_comb begin
		byte_count_d = byte_count_q;
		exp_len_d    = exp_len_q;
		sum_a_d      = sum_a_q;
		sum_b_d      = sum_b_q;
		src_d        = src_q;
		dst_d        = dst_q;
		cc_d         = cc_q;
		msg_d        = msg_q;
		ck_a_d       = ck_a_q;
		res_valid    = 1'b0;
		with_header  = 1'b1;
		res.kind          = cfr_pkg::KIND_PAYLOAD;
		res.data_byte     = '0;
		res.payload_index = '0;
		unique case (phase_q)
			cfr_pkg::PH_LEN: begin
				exp_len_d = rx_byte;
				sum_a_d   = sum_a_add;
				sum_b_d   = sum_b_add;
				if (rx_byte < cfr_pkg::MIN_LENGTH) begin
					res_valid   = 1'b1;
					with_header = 1'b0;
					res.kind    = cfr_pkg::KIND_SHORT;
				end else begin
					byte_count_d = 8'd2;
				end
			end
			cfr_pkg::PH_HEADER: begin
				sum_a_d      = sum_a_add;
				sum_b_d      = sum_b_add;
				byte_count_d = count_inc;
				case (byte_count_q)
					8'd2:    src_d = rx_byte;
					8'd3:    dst_d = rx_byte;
					8'd4:    cc_d  = rx_byte;
					default: msg_d = rx_byte;
				endcase
			end
			cfr_pkg::PH_PAYLOAD: begin
				sum_a_d           = sum_a_add;
				sum_b_d           = sum_b_add;
				byte_count_d      = count_inc;
				res_valid         = 1'b1;
				res.data_byte     = rx_byte;
				res.payload_index = byte_count_q - cfr_pkg::HEADER_END;
			end
			cfr_pkg::PH_CKA: begin
				ck_a_d = rx_byte;
			end
			cfr_pkg::PH_CKB: begin
				res_valid = 1'b1;
				res.kind  = (ck_a_q == sum_a_q && rx_byte == sum_b_q) ? cfr_pkg::KIND_GOOD
				                                                    : cfr_pkg::KIND_BAD;
			end
			default: begin
				// hunting: a start byte opens a fresh frame
				if (rx_byte == start_byte) begin
					sum_a_d      = '0;
					sum_b_d      = '0;
					byte_count_d = 8'd1;
					src_d        = '0;
					dst_d        = '0;
					cc_d         = '0;
					msg_d        = '0;
				end
			end
		endcase
		res.source_id    = with_header ? src_q : 8'd0;
		res.dest_id      = with_header ? dst_q : 8'd0;
		res.cls_code     = with_header ? cc_q[3:0] : 4'd0;
		res.comp_code    = with_header ? cc_q[7:4] : 4'd0;
		res.msg_code     = with_header ? msg_q : 8'd0;
		res.frame_length = exp_len_d;
	end

	// State registers, advanced once per accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= cfr_pkg::PH_HUNT;
			byte_count_q <= '0;
			exp_len_q    <= '0;
			sum_a_q      <= '0;
			sum_b_q      <= '0;
			src_q        <= '0;
			dst_q        <= '0;
			cc_q         <= '0;
			msg_q        <= '0;
			ck_a_q       <= '0;
		end else if (in_fire) begin
			phase_q      <= phase_d;
			byte_count_q <= byte_count_d;
			exp_len_q    <= exp_len_d;
			sum_a_q      <= sum_a_d;
			sum_b_q      <= sum_b_d;
			src_q        <= src_d;
			dst_q        <= dst_d;
			cc_q         <= cc_d;
			msg_q        <= msg_d;
			ck_a_q       <= ck_a_d;
		end
	end

endmodule

### sv/cfr_outq.sv
// Result register with a skid stage toward the output channel.
module cfr_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  cfr_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output cfr_pkg::result_t out_res,
	output logic             full
);

	`include "checksummed_frame_receiver_assert.svh"

	logic             out_v_q, skid_v_q;
	cfr_pkg::result_t out_q, skid_q;
	logic             out_free;

	assign out_free = !out_v_q || !out_stall;

	// Occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (out_free) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_v_q <= 1'b1;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_res   = out_q;
	assign full      = skid_v_q;

	`CFR_ASSERT(a_skid_behind_out, skid_v_q |-> out_v_q, "skid holds a beat while output is empty")
	`CFR_ASSERT(a_no_overrun, res_valid |-> !skid_v_q, "result arrived with skid stage full")
	`CFR_ASSERT(a_skid_fill_cause, $rose(skid_v_q) |-> $past(out_v_q && out_stall),
		"skid filled without a stalled output")
	`CFR_ASSERT_ALWAYS(a_reset_empty, !arst_n |-> (!out_v_q && !skid_v_q),
		"output stage not empty in reset")

endmodule

### sv/checksummed_frame_receiver.sv
// Top level of the checksummed frame receiver.
// Takes one received byte per beat, one beat per clock when the output keeps up.
// The byte is parsed in the same cycle it is accepted (phase, header capture and
// 8-bit Fletcher sums A and B updated in one pass) and any result is registered
// at that edge, in the output register or, behind a stalled result, in the skid.
// A two-entry output stage (result register plus skid) lets the next byte be
// taken while a result waits; in_stall rises only once both entries are full.
// Payload bytes come out as kind 0 as they arrive; the frame ends with a
// verdict: 1 good, 2 checksum mismatch, 3 length byte below 8. After any verdict
// the receiver hunts for start_byte again (register at address 0, reset 0x99).
module checksummed_frame_receiver (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [1:0]                  kind,
	output logic [7:0]                  data_byte,
	output logic [7:0]                  payload_index,
	output logic [7:0]                  source_id,
	output logic [7:0]                  dest_id,
	output logic [3:0]                  cls_code,
	output logic [3:0]                  comp_code,
	output logic [7:0]                  msg_code,
	output logic [7:0]                  frame_length
);

	logic             in_fire, res_valid, q_full;
	logic [7:0]       start_byte;
	cfr_pkg::result_t res, out_res;

	assign in_stall = q_full;
	assign in_fire  = in_valid & ~q_full;

	cfr_regs u_regs (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.start_byte (start_byte)
	);

	cfr_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.rx_byte    (rx_byte),
		.start_byte (start_byte),
		.res_valid  (res_valid),
		.res        (res)
	);

	cfr_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid & in_fire),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_res   (out_res),
		.full      (q_full)
	);

	// Result fields onto ports
	assign kind          = out_res.kind;
	assign data_byte     = out_res.data_byte;
	assign payload_index = out_res.payload_index;
	assign source_id     = out_res.source_id;
	assign dest_id       = out_res.dest_id;
	assign cls_code      = out_res.cls_code;
	assign comp_code     = out_res.comp_code;
	assign msg_code      = out_res.msg_code;
	assign frame_length  = out_res.frame_length;

endmodule

### tb/frame_checker.sv
// Scoreboard for the checksummed frame receiver: predicts every result beat and compares it.
`timescale 1ns / 100ps
module frame_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cfr_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic                        pready,
	input  logic                        in_valid,
	input  logic                        in_stall,
	input  logic [7:0]                  rx_byte,
	input  logic                        out_valid,
	input  logic                        out_stall,
	input  logic [1:0]                  kind,
	input  logic [7:0]                  data_byte,
	input  logic [7:0]                  payload_index,
	input  logic [7:0]                  source_id,
	input  logic [7:0]                  dest_id,
	input  logic [3:0]                  cls_code,
	input  logic [3:0]                  comp_code,
	input  logic [7:0]                  msg_code,
	input  logic [7:0]                  frame_length,
	output int                          mismatches,
	output int                          pending,
	output int                          bytes_taken,
	output int                          payload_seen,
	output int                          good_seen,
	output int                          bad_seen,
	output int                          short_seen
);

	localparam int MAX_REPORTS = 24;

	// Predicted receiver state
	logic [7:0]      marker;
	cfr_pkg::phase_t rx_phase;
	logic [7:0]      frame_pos;
	logic [7:0]      frame_len;
	logic [7:0]      run_a;
	logic [7:0]      run_b;
	logic [7:0]      hdr_src;
	logic [7:0]      hdr_dst;
	logic [7:0]      hdr_cls_comp;
	logic [7:0]      hdr_msg;
	logic [7:0]      got_check_a;

	// Results still owed by the receiver, oldest first
	cfr_pkg::result_t frame_results[$];

	function automatic void fletcher_add(input logic [7:0] b);
		run_a = run_a + b;
		run_b = run_b + run_a;
	endfunction

	// Result beat carrying the header of the current frame
	function automatic cfr_pkg::result_t framed(input cfr_pkg::kind_t k);
		cfr_pkg::result_t r;
		r = '0;
		r.kind         = k;
		r.source_id    = hdr_src;
		r.dest_id      = hdr_dst;
		r.cls_code     = hdr_cls_comp[3:0];
		r.comp_code    = hdr_cls_comp[7:4];
		r.msg_code     = hdr_msg;
		r.frame_length = frame_len;
		return r;
	endfunction

	// Advances the predicted deframer by one byte; returns 1 when a result is due
	function automatic bit deframe_byte(input logic [7:0] b, output cfr_pkg::result_t res);
		bit emit;
		emit = 1'b0;
		res  = '0;
		case (rx_phase)
			cfr_pkg::PH_LEN: begin
				frame_len = b;
				fletcher_add(b);
				if (b < cfr_pkg::MIN_LENGTH) begin
					// too short: no header fields, back to hunting
					res.kind         = cfr_pkg::KIND_SHORT;
					res.frame_length = b;
					rx_phase         = cfr_pkg::PH_HUNT;
					emit             = 1'b1;
				end else begin
					frame_pos = 8'd2;
					rx_phase  = cfr_pkg::PH_HEADER;
				end
			end
			cfr_pkg::PH_HEADER: begin
				fletcher_add(b);
				case (frame_pos)
					8'd2:    hdr_src      = b;
					8'd3:    hdr_dst      = b;
					8'd4:    hdr_cls_comp = b;
					default: hdr_msg      = b;
				endcase
				frame_pos = frame_pos + 8'd1;
				if (frame_pos >= cfr_pkg::HEADER_END)
					rx_phase = (frame_len == cfr_pkg::MIN_LENGTH) ? cfr_pkg::PH_CKA
					                                              : cfr_pkg::PH_PAYLOAD;
			end
			cfr_pkg::PH_PAYLOAD: begin
				fletcher_add(b);
				res               = framed(cfr_pkg::KIND_PAYLOAD);
				res.data_byte     = b;
				res.payload_index = frame_pos - cfr_pkg::HEADER_END;
				frame_pos         = frame_pos + 8'd1;
				if ({1'b0, frame_pos} + 9'd2 >= {1'b0, frame_len})
					rx_phase = cfr_pkg::PH_CKA;
				emit = 1'b1;
			end
			cfr_pkg::PH_CKA: begin
				got_check_a = b;
				rx_phase    = cfr_pkg::PH_CKB;
			end
			cfr_pkg::PH_CKB: begin
				res      = framed((got_check_a == run_a && b == run_b) ? cfr_pkg::KIND_GOOD
				                                                     : cfr_pkg::KIND_BAD);
				rx_phase = cfr_pkg::PH_HUNT;
				emit     = 1'b1;
			end
			default: begin
				rx_phase = cfr_pkg::PH_HUNT;
				if (b == marker) begin
					run_a        = '0;
					run_b        = '0;
					frame_pos    = 8'd1;
					hdr_src      = '0;
					hdr_dst      = '0;
					hdr_cls_comp = '0;
					hdr_msg      = '0;
					rx_phase     = cfr_pkg::PH_LEN;
				end
			end
		endcase
		return emit;
	endfunction

	task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("%0t: %s expected 0x%02h, got 0x%02h", $time, name, want, got);
		end
	endtask

	// Watch config writes, input beats and result beats
	always @(posedge clk or negedge arst_n) begin : watch
		cfr_pkg::result_t fresh;
		cfr_pkg::result_t want;
		if (!arst_n) begin
			marker       = cfr_pkg::START_RESET;
			rx_phase     = cfr_pkg::PH_HUNT;
			frame_pos    = '0;
			frame_len    = '0;
			run_a        = '0;
			run_b        = '0;
			hdr_src      = '0;
			hdr_dst      = '0;
			hdr_cls_comp = '0;
			hdr_msg      = '0;
			got_check_a  = '0;
			frame_results.delete();
			mismatches   = 0;
			bytes_taken  = 0;
			payload_seen = 0;
			good_seen    = 0;
			bad_seen     = 0;
			short_seen   = 0;
		end else begin
			if (psel && penable && pwrite && pready &&
				paddr[cfr_pkg::PADDR_W-1:2] == cfr_pkg::REG_START_BYTE)
				marker = pwdata[7:0];
			if (in_valid && !in_stall) begin
				bytes_taken++;
				if (deframe_byte(rx_byte, fresh))
					frame_results = {frame_results, fresh};
			end
			if (out_valid && !out_stall) begin
				if (frame_results.size() == 0) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("%0t: unexpected result beat, expected none, got kind %0d",
							$time, kind);
				end else begin
					want = frame_results.pop_front();
					check_field("kind", 8'(want.kind), 8'(kind));
					check_field("data_byte", want.data_byte, data_byte);
					check_field("payload_index", want.payload_index, payload_index);
					check_field("source_id", want.source_id, source_id);
					check_field("dest_id", want.dest_id, dest_id);
					check_field("cls_code", 8'(want.cls_code), 8'(cls_code));
					check_field("comp_code", 8'(want.comp_code), 8'(comp_code));
					check_field("msg_code", want.msg_code, msg_code);
					check_field("frame_length", want.frame_length, frame_length);
					case (want.kind)
						cfr_pkg::KIND_PAYLOAD: payload_seen++;
						cfr_pkg::KIND_GOOD:    good_seen++;
						cfr_pkg::KIND_BAD:     bad_seen++;
						default:               short_seen++;
					endcase
				end
			end
		end
		pending = frame_results.size();
	end

endmodule

### tb/tb.sv
// Top of the checksummed frame receiver testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 100ps
module tb;

	typedef enum int {FRAME_OK, FRAME_BAD_A, FRAME_BAD_B, FRAME_CUT} frame_flaw_t;
	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} stall_mode_t;

	localparam logic [cfr_pkg::PADDR_W-3:0] REG_SPARE = 1'b1;  // unmapped slot, writes ignored
	localparam int HOLD_CYCLES  = 300;
	localparam int DRAIN_CYCLES = 8;

	logic                        clk;
	logic                        arst_n;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [cfr_pkg::PADDR_W-1:0] paddr;
	logic [31:0]                 pwdata;
	logic [31:0]                 prdata;
	logic                        pready;
	logic                        in_valid;
	logic                        in_stall;
	logic [7:0]                  rx_byte;
	logic                        out_valid;
	logic                        out_stall;
	logic [1:0]                  kind;
	logic [7:0]                  data_byte;
	logic [7:0]                  payload_index;
	logic [7:0]                  source_id;
	logic [7:0]                  dest_id;
	logic [3:0]                  cls_code;
	logic [3:0]                  comp_code;
	logic [7:0]                  msg_code;
	logic [7:0]                  frame_length;

	int mismatches;
	int pending;
	int bytes_taken;
	int payload_seen;
	int good_seen;
	int bad_seen;
	int short_seen;

	// Stimulus knobs
	logic [7:0] cur_start   = cfr_pkg::START_RESET;
	int         burst_left  = 0;
	int         gap_max     = 0;
	int         marker_odds = 16;
	int         beats_sent  = 0;
	bit         hold_req    = 1'b0;

	checksummed_frame_receiver i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.payload_index (payload_index),
		.source_id     (source_id),
		.dest_id       (dest_id),
		.cls_code      (cls_code),
		.comp_code     (comp_code),
		.msg_code      (msg_code),
		.frame_length  (frame_length)
	);

	frame_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.pready        (pready),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.kind          (kind),
		.data_byte     (data_byte),
		.payload_index (payload_index),
		.source_id     (source_id),
		.dest_id       (dest_id),
		.cls_code      (cls_code),
		.comp_code     (comp_code),
		.msg_code      (msg_code),
		.frame_length  (frame_length),
		.mismatches    (mismatches),
		.pending       (pending),
		.bytes_taken   (bytes_taken),
		.payload_seen  (payload_seen),
		.good_seen     (good_seen),
		.bad_seen      (bad_seen),
		.short_seen    (short_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

	// Output stall: random stretches of different patterns, plus one long hold-off on request
	initial begin : rx_stall_gen
		stall_mode_t mode;
		int          span;
		int          period;
		out_stall = 1'b0;
		forever begin
			mode   = stall_mode_t'($urandom_range(0, 3));
			span   = $urandom_range(16, 160);
			period = $urandom_range(2, 6);
			for (int c = 0; c < span; c++) begin
				@(negedge clk);
				if (hold_req) begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
					hold_req = 1'b0;
				end
				case (mode)
					RX_FREE:  out_stall <= 1'b0;
					RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
					default:  out_stall <= ((c % period) == 0);
				endcase
			end
		end
	end

	// One input beat; opens a new burst, after a random gap, when the last one ran out
	task automatic send_byte(input logic [7:0] b, input bit counted);
		int gap;
		if (burst_left == 0) begin
			gap = 0;
			if (gap_max > 0 && $urandom_range(0, 2) != 0)
				gap = $urandom_range(1, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		rx_byte  <= b;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (counted)
			beats_sent++;
	endtask

	// Start byte, length, header (src, dst, class/comp, msg from low to high), payload, checksums
	task automatic send_frame(input logic [7:0] len, input logic [31:0] hdr,
		input frame_flaw_t flaw);
		logic [7:0] body[$];
		logic [7:0] ck_a;
		logic [7:0] ck_b;
		logic [7:0] pay;
		int         stop;
		body = {body, len};
		if (len >= cfr_pkg::MIN_LENGTH) begin
			body = {body, hdr[7:0]};
			body = {body, hdr[15:8]};
			body = {body, hdr[23:16]};
			body = {body, hdr[31:24]};
			repeat (int'(len) - 8) begin
				pay = 8'($urandom);
				if ($urandom_range(1, marker_odds) == 1)
					pay = cur_start;
				body = {body, pay};
			end
		end
		ck_a = '0;
		ck_b = '0;
		foreach (body[i]) begin
			ck_a = ck_a + body[i];
			ck_b = ck_b + ck_a;
		end
		if (flaw == FRAME_BAD_A)
			ck_a = ck_a ^ 8'($urandom_range(1, 255));
		if (flaw == FRAME_BAD_B)
			ck_b = ck_b ^ 8'($urandom_range(1, 255));
		if (len >= cfr_pkg::MIN_LENGTH) begin
			body = {body, ck_a};
			body = {body, ck_b};
		end
		stop = body.size();
		if (flaw == FRAME_CUT && stop > 1)
			stop = $urandom_range(1, stop - 1);
		send_byte(cur_start, 1'b1);
		for (int i = 0; i < stop; i++)
			send_byte(body[i], 1'b1);
	endtask

	function automatic logic [7:0] pick_length();
		if ($urandom_range(0, 24) == 0)
			return 8'($urandom_range(29, 120));
		return 8'($urandom_range(8, 28));
	endfunction

	// Mostly well-formed frames, the rest corrupt, short, cut off or line noise
	task automatic random_traffic(input int quota);
		int         target;
		int         pick;
		logic [7:0] junk;
		target = beats_sent + quota;
		while (beats_sent < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 68)
				send_frame(pick_length(), $urandom, FRAME_OK);
			else if (pick < 76)
				send_frame(pick_length(), $urandom,
					($urandom_range(0, 1) == 0) ? FRAME_BAD_A : FRAME_BAD_B);
			else if (pick < 83)
				send_frame(8'($urandom_range(0, 7)), $urandom, FRAME_OK);
			else if (pick < 88)
				send_frame(pick_length(), $urandom, FRAME_CUT);
			else begin
				repeat ($urandom_range(1, 4)) begin
					junk = 8'($urandom);
					if (junk == cur_start)
						junk = junk ^ 8'h01;
					send_byte(junk, 1'b0);
				end
			end
		end
	endtask

	// Sender goes quiet until every predicted result has come out, then lets the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// APB write: setup then access, register taken at the access edge, then the bus returns to idle
	task automatic cfg_write(input logic [cfr_pkg::PADDR_W-3:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == cfr_pkg::REG_START_BYTE)
			cur_start = value[7:0];
		@(negedge clk);
	endtask

	initial begin : stimulus
		arst_n   = 1'b0;
		psel     = 1'b0;
		penable  = 1'b0;
		pwrite   = 1'b0;
		paddr    = '0;
		pwdata   = '0;
		in_valid = 1'b0;
		rx_byte  = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: noise while hunting, short lengths, empty payload, marker inside payload
		gap_max     = 2;
		marker_odds = 1;
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_frame(8'd0, '0, FRAME_OK);
		send_frame(8'd7, '0, FRAME_OK);
		send_frame(cfr_pkg::MIN_LENGTH, 32'hFF5A_00FF, FRAME_OK);
		send_frame(8'd9, 32'h00A5_FF00, FRAME_BAD_B);
		marker_odds = 16;

		// Random traffic with the reset marker, then a long output hold-off under full load
		gap_max = 6;
		random_traffic(80);
		gap_max  = 0;
		hold_req = 1'b1;
		send_frame(8'd60, $urandom, FRAME_OK);
		drain();
		gap_max = 4;
		random_traffic(20);

		// Marker 0x00 with heavy input idling; the spare register slot must be ignored
		drain();
		cfg_write(REG_SPARE, $urandom);
		cfg_write(cfr_pkg::REG_START_BYTE, $urandom & 32'hFFFF_FF00);
		gap_max = 30;
		random_traffic(80);

		// Marker 0xFF, back-to-back input, longest frame
		drain();
		cfg_write(cfr_pkg::REG_START_BYTE, ($urandom & 32'hFFFF_FF00) | 32'h0000_00FF);
		gap_max = 0;
		send_frame(8'd255, $urandom, FRAME_OK);
		random_traffic(20);

		// Random marker
		drain();
		cfg_write(cfr_pkg::REG_START_BYTE, $urandom);
		gap_max = 3;
		random_traffic(80);

		drain();
		$display("Covered %0d input beats: %0d payload, %0d good, %0d corrupt, %0d short,",
			bytes_taken, payload_seen, good_seen, bad_seen, short_seen);
		$display("over four start markers (last 0x%02h), one long output hold-off and drains.",
			cur_start);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
